[rtl/core/i2cbb_pkg.sv]
// shared types, codes and reset values for the bit-banged i2c master
`default_nettype none
package i2cbb_pkg;

  localparam logic [2:0] ACT_START = 3'd0;
  localparam logic [2:0] ACT_STOP  = 3'd1;
  localparam logic [2:0] ACT_SEND  = 3'd2;
  localparam logic [2:0] ACT_READ  = 3'd3;
  localparam logic [2:0] ACT_ACK   = 3'd4;
  localparam logic [2:0] ACT_NACK  = 3'd5;
  localparam logic [2:0] ACT_WAIT  = 3'd6;

  localparam logic [1:0] CFG_HALF    = 2'd0;
  localparam logic [1:0] CFG_HOLD    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [15:0] HALF_RST    = 16'd5;
  localparam logic [15:0] HOLD_RST    = 16'd30;
  localparam logic [15:0] TIMEOUT_RST = 16'd10000;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_SEG1 = 5'b00010,
    PH_SEG2 = 5'b00100,
    PH_SEG3 = 5'b01000,
    PH_SEG4 = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] action;
    logic [7:0] write_data;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_bit;
  } out_t;

  typedef struct packed {
    logic [15:0] half_ticks;
    logic [15:0] hold_ticks;
    logic [15:0] ack_timeout;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/core/i2cbb_seq.sv]
// command sequencer: bus state registers and per-tick step logic
`default_nettype none
module i2cbb_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire i2cbb_pkg::in_t  item,
  input  wire i2cbb_pkg::cfg_t cfg,
  output i2cbb_pkg::out_t    res
);
  import i2cbb_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  act_r, act_nxt;
  logic [15:0] wc_r, wc_nxt;
  logic [3:0]  bc_r, bc_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        drv_r, drv_nxt;
  logic [7:0]  recv_r, recv_nxt;
  logic        ack_r, ack_nxt;
  logic        done;

  logic [15:0] half_span, hold_span, limit, poll_inc;
  logic        poll_en;
  logic [15:0] poll_base;
  logic [3:0]  bc_inc;

  assign half_span = (cfg.half_ticks != 16'd0) ? cfg.half_ticks - 16'd1 : 16'd0;
  assign hold_span = (cfg.hold_ticks != 16'd0) ? cfg.hold_ticks - 16'd1 : 16'd0;
  assign limit     = (cfg.ack_timeout != 16'd0) ? cfg.ack_timeout : 16'd1;
  assign bc_inc    = bc_r + 4'd1;

  always_comb begin
    phase_nxt = phase_r;
    act_nxt   = act_r;
    wc_nxt    = wc_r;
    bc_nxt    = bc_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    drv_nxt   = drv_r;
    recv_nxt  = recv_r;
    ack_nxt   = ack_r;
    done      = 1'b0;
    poll_en   = 1'b0;
    poll_base = wc_r;
    poll_inc  = 16'd0;

    if (phase_r == PH_IDLE) begin
      if (item.cmd_valid && item.action <= ACT_WAIT) begin
        act_nxt   = item.action;
        bc_nxt    = 4'd0;
        phase_nxt = PH_SEG1;
        case (item.action)
          ACT_START: begin
            scl_nxt = 1'b1; sda_nxt = 1'b1; drv_nxt = 1'b1; wc_nxt = hold_span;
          end
          ACT_STOP: begin
            scl_nxt = 1'b0; sda_nxt = 1'b0; drv_nxt = 1'b1; wc_nxt = hold_span;
          end
          ACT_SEND: begin
            shift_nxt = item.write_data; scl_nxt = 1'b0; drv_nxt = 1'b1;
            wc_nxt = half_span;
          end
          ACT_READ: begin
            shift_nxt = 8'd0; drv_nxt = 1'b0; sda_nxt = 1'b1; wc_nxt = half_span;
          end
          ACT_ACK, ACT_NACK: begin
            scl_nxt = 1'b0; drv_nxt = 1'b1; sda_nxt = (item.action == ACT_NACK);
            wc_nxt = half_span;
          end
          default: begin
            drv_nxt = 1'b0; sda_nxt = 1'b1; scl_nxt = 1'b0; wc_nxt = half_span;
          end
        endcase
      end
    end else if (act_r == ACT_WAIT && phase_r == PH_SEG2) begin
      poll_en = 1'b1;
    end else if (wc_r != 16'd0) begin
      wc_nxt = wc_r - 16'd1;
    end else begin
      case (act_r)
        ACT_START: begin
          if (phase_r == PH_SEG1) begin
            sda_nxt = 1'b0; phase_nxt = PH_SEG2; wc_nxt = hold_span;
          end else begin
            scl_nxt = 1'b0; phase_nxt = PH_IDLE; bc_nxt = 4'd0; done = 1'b1;
          end
        end
        ACT_STOP: begin
          if (phase_r == PH_SEG1) begin
            scl_nxt = 1'b1; phase_nxt = PH_SEG2; wc_nxt = hold_span;
          end else begin
            sda_nxt = 1'b1; phase_nxt = PH_IDLE; bc_nxt = 4'd0; done = 1'b1;
          end
        end
        ACT_ACK, ACT_NACK: begin
          if (phase_r == PH_SEG1) begin
            scl_nxt = 1'b1; phase_nxt = PH_SEG2; wc_nxt = half_span;
          end else begin
            scl_nxt = 1'b0; phase_nxt = PH_IDLE; bc_nxt = 4'd0; done = 1'b1;
          end
        end
        ACT_SEND: begin
          if (phase_r == PH_SEG1 || phase_r == PH_SEG3) begin
            if (phase_r == PH_SEG3 && bc_inc >= BITS_PER_BYTE) begin
              phase_nxt = PH_IDLE; bc_nxt = 4'd0; done = 1'b1;
            end else begin
              if (phase_r == PH_SEG3) bc_nxt = bc_inc;
              sda_nxt   = shift_r[7];
              shift_nxt = {shift_r[6:0], 1'b0};
              scl_nxt   = 1'b1;
              phase_nxt = PH_SEG2;
              wc_nxt    = half_span;
            end
          end else begin
            scl_nxt = 1'b0; phase_nxt = PH_SEG3; wc_nxt = half_span;
          end
        end
        ACT_READ: begin
          if (phase_r == PH_SEG2) begin
            scl_nxt = 1'b1; phase_nxt = PH_SEG3; wc_nxt = half_span;
          end else if (phase_r == PH_SEG3 && bc_inc >= BITS_PER_BYTE) begin
            shift_nxt = {shift_r[6:0], item.sda_in};
            recv_nxt  = {shift_r[6:0], item.sda_in};
            scl_nxt   = 1'b0; drv_nxt = 1'b1;
            phase_nxt = PH_IDLE; bc_nxt = 4'd0; done = 1'b1;
          end else begin
            if (phase_r == PH_SEG3) begin
              shift_nxt = {shift_r[6:0], item.sda_in};
              bc_nxt    = bc_inc;
            end
            scl_nxt = 1'b0; phase_nxt = PH_SEG2; wc_nxt = half_span;
          end
        end
        default: begin
          if (phase_r == PH_SEG1) begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_SEG2;
            poll_en   = 1'b1;
            poll_base = 16'd0;
          end else if (phase_r == PH_SEG3) begin
            scl_nxt = 1'b0; phase_nxt = PH_SEG4; wc_nxt = half_span;
          end else begin
            drv_nxt = 1'b1; sda_nxt = 1'b1;
            phase_nxt = PH_IDLE; bc_nxt = 4'd0; done = 1'b1;
          end
        end
      endcase
    end

    if (poll_en) begin
      poll_inc = poll_base + 16'd1;
      if (!item.sda_in) begin
        ack_nxt = 1'b0; phase_nxt = PH_SEG3; wc_nxt = 16'd0;
      end else if (poll_inc >= limit) begin
        ack_nxt = 1'b1; phase_nxt = PH_SEG3; wc_nxt = 16'd0;
      end else begin
        wc_nxt = poll_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      act_r   <= ACT_START;
      wc_r    <= 16'd0;
      bc_r    <= 4'd0;
      shift_r <= 8'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      drv_r   <= 1'b1;
      recv_r  <= 8'd0;
      ack_r   <= 1'b1;
    end else if (step) begin
      phase_r <= phase_nxt;
      act_r   <= act_nxt;
      wc_r    <= wc_nxt;
      bc_r    <= bc_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      drv_r   <= drv_nxt;
      recv_r  <= recv_nxt;
      ack_r   <= ack_nxt;
    end
  end

  always_comb begin
    res.scl_level = scl_nxt;
    res.sda_level = sda_nxt;
    res.sda_drive = drv_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.read_data = recv_nxt;
    res.ack_bit   = ack_nxt;
  end

endmodule
`default_nettype wire

[rtl/core/i2c_bit_bang_master.sv]
// top level of the bit-banged i2c master: config registers, sequencer and result register
//
// Each transfer on the in_ channel is one bus tick (about a microsecond) carrying
// the sampled SDA level and, optionally, a command; commands are taken only
// while no sequence is running, and otherwise ignored. Every accepted tick gives
// exactly one transfer on the out_ channel with the pin levels, SDA drive enable,
// busy, done, the last read byte and the last acknowledge result.
// The result is registered and valid in the cycle after the input transfer;
// throughput is one tick per cycle while in_stall is low.
// The result register holds a finished result while the receiver stalls; in_stall
// rises only when that register is full and out_stall is high, so a result taken
// in the same cycle lets the next tick in.
// The cfg_ port writes half period, hold and ack timeout by index; a zero value
// counts as one. Write only while idle.
// Reset is synchronous, active low: bus lines idle high with SDA driven, no
// result pending, registers back to 5, 30 and 10000 ticks.
`default_nettype none
module i2c_bit_bang_master (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire i2cbb_pkg::in_t   in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output i2cbb_pkg::out_t       out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data
);
  import i2cbb_pkg::*;

  cfg_t  cfg_r;
  logic  out_valid_r;
  out_t  out_data_r;
  out_t  res;
  logic  accept;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_ticks  <= HALF_RST;
      cfg_r.hold_ticks  <= HOLD_RST;
      cfg_r.ack_timeout <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF:    cfg_r.half_ticks  <= cfg_data;
        CFG_HOLD:    cfg_r.hold_ticks  <= cfg_data;
        CFG_TIMEOUT: cfg_r.ack_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  i2cbb_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (accept),
    .item  (in_data),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
